// File: rtl/core/c8_pkg.sv
`default_nettype none

package c8_pkg;

    // memory geometry
    localparam int MEM_BYTES    = 4096;
    localparam int MEM_AW       = 12;
    localparam int FRAME_BYTES  = 256;
    localparam int FRAME_AW     = 8;
    localparam int STACK_DEPTH  = 16;
    localparam int FONT_LEN     = 80;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [11:0] PROG_BASE = 12'h200;

    // input actions
    localparam logic [2:0] ACT_LOAD = 3'd0;
    localparam logic [2:0] ACT_EXEC = 3'd1;
    localparam logic [2:0] ACT_TICK = 3'd2;
    localparam logic [2:0] ACT_KEY  = 3'd3;
    localparam logic [2:0] ACT_READ = 3'd4;

    // run modes
    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    // fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd1;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;
    localparam logic [1:0] FAULT_OPCODE    = 2'd3;

    // opcode groups
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEB  = 4'h3;
    localparam logic [3:0] OP_SNEB = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDB  = 4'h6;
    localparam logic [3:0] OP_ADDB = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // instruction costs in microseconds
    localparam logic [14:0] COST_CLS  = 15'd109;
    localparam logic [14:0] COST_JUMP = 15'd105;
    localparam logic [14:0] COST_SKB  = 15'd55;
    localparam logic [14:0] COST_SKR  = 15'd73;
    localparam logic [14:0] COST_LDB  = 15'd27;
    localparam logic [14:0] COST_MOV  = 15'd45;
    localparam logic [14:0] COST_ALU  = 15'd200;
    localparam logic [14:0] COST_RND  = 15'd164;
    localparam logic [14:0] COST_DRW  = 15'd22734;
    localparam logic [14:0] COST_ADDI = 15'd86;
    localparam logic [14:0] COST_FONT = 15'd91;
    localparam logic [14:0] COST_BCD  = 15'd927;
    localparam logic [14:0] COST_BLK  = 15'd605;

    typedef enum logic [3:0] {
        ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
        ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL, ALU_EQ
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y,
        ST_EXEC, ST_WRITE_VF, ST_CLS, ST_SPR_ROW, ST_SPR_RD1, ST_SPR_WR1,
        ST_SPR_RD2, ST_SPR_WR2, ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR,
        ST_DISP, ST_FINISH
    } state_t;

    localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
        8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
        8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
        8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
        8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
    };

    // decimal digits of a byte: {hundreds, tens, ones}
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [7:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - ({6'd0, h} * 8'd100);
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = r - ({4'd0, t} * 8'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/c8_ram.sv
`default_nettype none

module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/c8_alu.sv
`default_nettype none

module c8_alu (
    input  wire c8_pkg::alu_op_t op,
    input  wire logic [7:0]      a,
    input  wire logic [7:0]      b,
    output logic      [7:0]      result,
    output logic                 flag
);

    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    // shared byte unit for register ops, adds and compares
    always_comb
    begin
        result = b;
        flag   = 1'b0;
        case (op)
            ALU_PASS: result = b;
            ALU_OR:   result = a | b;
            ALU_AND:  result = a & b;
            ALU_XOR:  result = a ^ b;
            ALU_ADD:
            begin
                result = sum[7:0];
                flag   = sum[8];
            end
            ALU_SUB:
            begin
                result = a - b;
                flag   = (a >= b);
            end
            ALU_SHR:
            begin
                result = {1'b0, b[7:1]};
                flag   = b[0];
            end
            ALU_SUBN:
            begin
                result = b - a;
                flag   = (b >= a);
            end
            ALU_SHL:
            begin
                result = {b[6:0], 1'b0};
                flag   = b[7];
            end
            ALU_EQ:
            begin
                result = a;
                flag   = (a == b);
            end
            default:
            begin
                result = b;
                flag   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/chip8_cpu_core_top.sv
// CHIP-8 processor core with its own 4 KiB memory and 64x32 display store.
// Command channel: an item is taken at a clock edge with start high and busy
// low; action picks load byte, execute, timer tick, key release or display
// read. Every item gives one result beat: done is high for exactly one cycle
// with run_state, program_counter, fault, read_data, sound_on and cost_us.
// The receiver cannot stall; the beat is gone after that cycle.
// Load, tick and key release go from idle to done, a display read through a
// read state. Execute fetches both instruction bytes, reads Vx and Vy and
// executes; a flag write to VF, a screen clear of 256 display bytes, a
// sprite draw (one or two display bytes per row, then VF), BCD, block store
// and block load add states. A new item can be taken the cycle after done.
// Memory traffic goes through RAMs with one write port and a registered
// read, and register-file traffic through one read and one write port,
// which sets the per-step cost of the fetch, sprite and block sequences.
// After reset a clearing pass writes the memory (font at 0x50) and the
// display; busy stays high until it ends.
`default_nettype none

module chip8_cpu_core_top #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [11:0] address,
    input  wire logic [7:0]  load_data,
    input  wire logic [15:0] key_mask,
    input  wire logic [3:0]  released_key,
    input  wire logic [7:0]  random_byte,
    output logic             done,
    output logic [1:0]       run_state,
    output logic [11:0]      program_counter,
    output logic [1:0]       fault,
    output logic [7:0]       read_data,
    output logic             sound_on,
    output logic [14:0]      cost_us
);

    import c8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    state_t state_reg, state_next, exec_target;

    logic [1:0]  mode_reg, mode_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [SPW-1:0] sp_reg, sp_next, sp_dec;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  sound_reg, sound_next;
    logic [3:0]  wait_reg, wait_next;
    logic [1:0]  fault_reg, fault_next;
    logic [14:0] cost_reg, cost_next;
    logic [7:0]  rd_reg, rd_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [15:0] key_reg, key_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [7:0]  hi_reg, hi_next, lo_reg, lo_next;
    logic [7:0]  a_reg, a_next, b_reg, b_next;
    logic        flag_reg, flag_next;
    logic [7:0]  hit_reg, hit_next;
    logic [7:0]  row_reg, row_next;
    logic [5:0]  px_reg, px_next;
    logic [4:0]  py_reg, py_next;
    logic [11:0] bcd_reg, bcd_next;

    logic [7:0]  vreg [16];
    logic [11:0] stack_mem [STACK_DEPTH];

    logic        accept;
    logic [3:0]  op, xr, nr;
    logic [11:0] nnn, pc2, pc4, i12, ik;
    logic [3:0]  k4;
    logic [7:0]  d1, d2, m1, m2;
    logic [2:0]  sh;
    logic        last_row, last_reg, stack_full;

    logic        mem_we, frm_we, rf_we, push;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic [7:0]  frm_waddr, frm_raddr, frm_wdata, frm_rdata;
    logic [3:0]  rf_waddr, rf_raddr;
    logic [7:0]  rf_wdata, rf_rdata;

    alu_op_t     alu_op;
    logic [7:0]  alu_b, alu_res;
    logic        alu_flag;
    logic [6:0]  font_idx;

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    c8_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (frm_wdata),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    c8_alu u_alu (
        .op     (alu_op),
        .a      (a_reg),
        .b      (alu_b),
        .result (alu_res),
        .flag   (alu_flag)
    );

    // decode helpers
    assign accept     = start && !busy;
    assign op         = hi_reg[7:4];
    assign xr         = hi_reg[3:0];
    assign nr         = lo_reg[3:0];
    assign nnn        = {xr, lo_reg};
    assign pc2        = pc_reg + 12'd2;
    assign pc4        = pc_reg + 12'd4;
    assign i12        = idx_reg[11:0];
    assign k4         = cnt_reg[3:0];
    assign ik         = i12 + {8'd0, k4};
    assign sh         = px_reg[2:0];
    assign d1         = {5'(py_reg + {1'b0, k4}), px_reg[5:3]};
    assign d2         = {d1[7:3], px_reg[5:3] + 3'd1};
    assign m1         = row_reg >> sh;
    assign m2         = 8'(row_reg << (4'd8 - {1'b0, sh}));
    assign last_row   = ((k4 + 4'd1) == nr);
    assign last_reg   = (k4 == xr);
    assign sp_dec     = sp_reg - 1'b1;
    assign stack_full = (sp_reg >= SPW'(STACK_DEPTH));
    assign font_idx   = 7'(cnt_reg - FONT_BASE);
    assign rf_rdata   = vreg[rf_raddr];
    assign alu_b      = ((op == OP_SEB) || (op == OP_SNEB) || (op == OP_ADDB)) ? lo_reg : b_reg;

    // alu operation select
    always_comb
    begin
        alu_op = ALU_EQ;
        if (op == OP_ADDB)
        begin
            alu_op = ALU_ADD;
        end
        else if (op == OP_ALU)
        begin
            case (nr)
                4'h0:    alu_op = ALU_PASS;
                4'h1:    alu_op = ALU_OR;
                4'h2:    alu_op = ALU_AND;
                4'h3:    alu_op = ALU_XOR;
                4'h4:    alu_op = ALU_ADD;
                4'h5:    alu_op = ALU_SUB;
                4'h6:    alu_op = ALU_SHR;
                4'h7:    alu_op = ALU_SUBN;
                4'hE:    alu_op = ALU_SHL;
                default: alu_op = ALU_EQ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (cnt_reg == 12'(MEM_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    if (action == ACT_READ)
                        state_next = ST_DISP;
                    else if ((action == ACT_EXEC) && (mode_reg == MODE_RUN))
                        state_next = ST_FETCH_HI;
                    else
                        state_next = ST_FINISH;
                end
            ST_FETCH_HI: state_next = ST_FETCH_LO;
            ST_FETCH_LO: state_next = ST_READ_X;
            ST_READ_X:   state_next = ST_READ_Y;
            ST_READ_Y:   state_next = ST_EXEC;
            ST_EXEC:     state_next = exec_target;
            ST_WRITE_VF: state_next = ST_FINISH;
            ST_CLS:
                if (cnt_reg[7:0] == 8'hff) state_next = ST_FINISH;
            ST_SPR_ROW:  state_next = ST_SPR_RD1;
            ST_SPR_RD1:  state_next = ST_SPR_WR1;
            ST_SPR_WR1:
                if (sh != 3'd0)
                    state_next = ST_SPR_RD2;
                else
                    state_next = last_row ? ST_WRITE_VF : ST_SPR_ROW;
            ST_SPR_RD2:  state_next = ST_SPR_WR2;
            ST_SPR_WR2:  state_next = last_row ? ST_WRITE_VF : ST_SPR_ROW;
            ST_BCD:
                if (cnt_reg[1:0] == 2'd2) state_next = ST_FINISH;
            ST_STORE:
                if (last_reg) state_next = ST_FINISH;
            ST_LOAD_RD:  state_next = ST_LOAD_WR;
            ST_LOAD_WR:  state_next = last_reg ? ST_FINISH : ST_LOAD_RD;
            ST_DISP:     state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and port controls per state
    always_comb
    begin
        mode_next  = mode_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        wait_next  = wait_reg;
        fault_next = fault_reg;
        cost_next  = cost_reg;
        rd_next    = rd_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        rnd_next   = rnd_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        flag_next  = flag_reg;
        hit_next   = hit_reg;
        row_next   = row_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        bcd_next   = bcd_reg;
        exec_target = ST_FINISH;
        mem_we    = 1'b0;
        mem_waddr = ik;
        mem_wdata = 8'd0;
        mem_raddr = pc_reg;
        frm_we    = 1'b0;
        frm_waddr = d1;
        frm_wdata = 8'd0;
        frm_raddr = d1;
        rf_we     = 1'b0;
        rf_waddr  = xr;
        rf_wdata  = alu_res;
        rf_raddr  = xr;
        push      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // memory and display sweep after reset
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = ((cnt_reg >= FONT_BASE) && (cnt_reg < FONT_BASE + 12'(FONT_LEN)))
                            ? FONT_ROM[font_idx] : 8'd0;
                frm_we    = 1'b1;
                frm_waddr = cnt_reg[7:0];
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_IDLE:
            begin
                frm_raddr = address[7:0];
                if (accept)
                begin
                    fault_next = FAULT_NONE;
                    cost_next  = 15'd0;
                    rd_next    = 8'd0;
                    key_next   = key_mask;
                    rnd_next   = random_byte;
                    cnt_next   = 12'd0;
                    case (action)
                        ACT_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = address;
                            mem_wdata = load_data;
                        end
                        ACT_TICK:
                            if (mode_reg != MODE_STOP)
                            begin
                                if (delay_reg != 8'd0) delay_next = delay_reg - 8'd1;
                                if (sound_reg != 8'd0) sound_next = sound_reg - 8'd1;
                            end
                        ACT_KEY:
                            if (mode_reg == MODE_WAIT)
                            begin
                                rf_we     = 1'b1;
                                rf_waddr  = wait_reg;
                                rf_wdata  = {4'd0, released_key};
                                mode_next = MODE_RUN;
                            end
                        default: ;
                    endcase
                end
            end
            ST_FETCH_HI:
                mem_raddr = pc_reg;
            ST_FETCH_LO:
            begin
                mem_raddr = pc_reg + 12'd1;
                hi_next   = mem_rdata;
            end
            ST_READ_X:
            begin
                lo_next  = mem_rdata;
                rf_raddr = xr;
                a_next   = rf_rdata;
            end
            ST_READ_Y:
            begin
                rf_raddr = (op == OP_JPV0) ? 4'd0 : lo_reg[7:4];
                b_next   = rf_rdata;
            end
            ST_EXEC:
            begin
                pc_next = pc2;
                case (op)
                    OP_SYS:
                        if ((xr == 4'd0) && (lo_reg == 8'he0))
                        begin
                            cost_next   = COST_CLS;
                            exec_target = ST_CLS;
                        end
                        else if ((xr == 4'd0) && (lo_reg == 8'hee))
                        begin
                            if (sp_reg == '0)
                            begin
                                mode_next  = MODE_STOP;
                                fault_next = FAULT_UNDERFLOW;
                            end
                            else
                            begin
                                sp_next   = sp_dec;
                                pc_next   = stack_mem[sp_dec[SIW-1:0]];
                                cost_next = COST_JUMP;
                            end
                        end
                        else
                        begin
                            mode_next  = MODE_STOP;
                            fault_next = FAULT_OPCODE;
                        end
                    OP_JP:
                    begin
                        pc_next   = nnn;
                        cost_next = COST_JUMP;
                    end
                    OP_CALL:
                        if (stack_full)
                        begin
                            mode_next  = MODE_STOP;
                            fault_next = FAULT_OVERFLOW;
                        end
                        else
                        begin
                            push      = 1'b1;
                            sp_next   = sp_reg + 1'b1;
                            pc_next   = nnn;
                            cost_next = COST_JUMP;
                        end
                    OP_SEB:
                    begin
                        if (alu_flag) pc_next = pc4;
                        cost_next = COST_SKB;
                    end
                    OP_SNEB:
                    begin
                        if (!alu_flag) pc_next = pc4;
                        cost_next = COST_SKB;
                    end
                    OP_SER, OP_SNER:
                        if (nr != 4'd0)
                        begin
                            mode_next  = MODE_STOP;
                            fault_next = FAULT_OPCODE;
                        end
                        else
                        begin
                            if (alu_flag == (op == OP_SER)) pc_next = pc4;
                            cost_next = COST_SKR;
                        end
                    OP_LDB:
                    begin
                        rf_we     = 1'b1;
                        rf_wdata  = lo_reg;
                        cost_next = COST_LDB;
                    end
                    OP_ADDB:
                    begin
                        rf_we     = 1'b1;
                        cost_next = COST_MOV;
                    end
                    OP_ALU:
                        if (alu_op == ALU_EQ)
                        begin
                            mode_next  = MODE_STOP;
                            fault_next = FAULT_OPCODE;
                        end
                        else
                        begin
                            rf_we     = 1'b1;
                            cost_next = COST_ALU;
                            if (nr != 4'd0)
                            begin
                                flag_next   = alu_flag;
                                exec_target = ST_WRITE_VF;
                            end
                        end
                    OP_LDI:
                    begin
                        idx_next  = {4'd0, nnn};
                        cost_next = COST_SKB;
                    end
                    OP_JPV0:
                    begin
                        pc_next   = nnn + {4'd0, b_reg};
                        cost_next = COST_JUMP;
                    end
                    OP_RND:
                    begin
                        rf_we     = 1'b1;
                        rf_wdata  = rnd_reg & lo_reg;
                        cost_next = COST_RND;
                    end
                    OP_DRW:
                    begin
                        px_next   = a_reg[5:0];
                        py_next   = b_reg[4:0];
                        hit_next  = 8'd0;
                        flag_next = 1'b0;
                        cost_next = COST_DRW;
                        exec_target = (nr == 4'd0) ? ST_WRITE_VF : ST_SPR_ROW;
                    end
                    OP_KEY:
                        if ((lo_reg == 8'h9e) || (lo_reg == 8'ha1))
                        begin
                            if (((a_reg < 8'd16) && key_reg[a_reg[3:0]]) == (lo_reg == 8'h9e))
                                pc_next = pc4;
                            cost_next = COST_SKR;
                        end
                        else
                        begin
                            mode_next  = MODE_STOP;
                            fault_next = FAULT_OPCODE;
                        end
                    default:
                        case (lo_reg)
                            8'h07:
                            begin
                                rf_we     = 1'b1;
                                rf_wdata  = delay_reg;
                                cost_next = COST_MOV;
                            end
                            8'h0a:
                            begin
                                wait_next = xr;
                                mode_next = MODE_WAIT;
                            end
                            8'h15:
                            begin
                                delay_next = a_reg;
                                cost_next  = COST_MOV;
                            end
                            8'h18:
                            begin
                                sound_next = a_reg;
                                cost_next  = COST_MOV;
                            end
                            8'h1e:
                            begin
                                idx_next  = idx_reg + {8'd0, a_reg};
                                cost_next = COST_ADDI;
                            end
                            8'h29:
                            begin
                                idx_next  = {4'd0, FONT_BASE} + {6'd0, a_reg, 2'b00}
                                            + {8'd0, a_reg};
                                cost_next = COST_FONT;
                            end
                            8'h33:
                            begin
                                bcd_next    = bcd_digits(a_reg);
                                cost_next   = COST_BCD;
                                exec_target = ST_BCD;
                            end
                            8'h55:
                            begin
                                cost_next   = COST_BLK;
                                exec_target = ST_STORE;
                            end
                            8'h65:
                            begin
                                cost_next   = COST_BLK;
                                exec_target = ST_LOAD_RD;
                            end
                            default:
                            begin
                                mode_next  = MODE_STOP;
                                fault_next = FAULT_OPCODE;
                            end
                        endcase
                endcase
            end
            ST_WRITE_VF:
            begin
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, flag_reg};
            end
            ST_CLS:
            begin
                frm_we    = 1'b1;
                frm_waddr = cnt_reg[7:0];
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_SPR_ROW:
                mem_raddr = ik;
            ST_SPR_RD1:
            begin
                row_next  = mem_rdata;
                frm_raddr = d1;
            end
            ST_SPR_WR1:
            begin
                // xor the left part of the row
                frm_we    = 1'b1;
                frm_waddr = d1;
                frm_wdata = frm_rdata ^ m1;
                hit_next  = hit_reg | (frm_rdata & m1);
                if ((sh == 3'd0) && last_row) flag_next = (hit_next != 8'd0);
                if (sh == 3'd0) cnt_next = cnt_reg + 12'd1;
            end
            ST_SPR_RD2:
                frm_raddr = d2;
            ST_SPR_WR2:
            begin
                // xor the part that spills into the next byte, wrapping in the row
                frm_we    = 1'b1;
                frm_waddr = d2;
                frm_wdata = frm_rdata ^ m2;
                hit_next  = hit_reg | (frm_rdata & m2);
                if (last_row) flag_next = (hit_next != 8'd0);
                cnt_next  = cnt_reg + 12'd1;
            end
            ST_BCD:
            begin
                mem_we    = 1'b1;
                mem_waddr = i12 + {10'd0, cnt_reg[1:0]};
                case (cnt_reg[1:0])
                    2'd0:    mem_wdata = {4'd0, bcd_reg[11:8]};
                    2'd1:    mem_wdata = {4'd0, bcd_reg[7:4]};
                    default: mem_wdata = {4'd0, bcd_reg[3:0]};
                endcase
                cnt_next = cnt_reg + 12'd1;
            end
            ST_STORE:
            begin
                rf_raddr  = k4;
                mem_we    = 1'b1;
                mem_waddr = ik;
                mem_wdata = rf_rdata;
                cnt_next  = cnt_reg + 12'd1;
                if (last_reg) idx_next = idx_reg + {12'd0, xr} + 16'd1;
            end
            ST_LOAD_RD:
                mem_raddr = ik;
            ST_LOAD_WR:
            begin
                rf_we    = 1'b1;
                rf_waddr = k4;
                rf_wdata = mem_rdata;
                cnt_next = cnt_reg + 12'd1;
                if (last_reg) idx_next = idx_reg + {12'd0, xr} + 16'd1;
            end
            ST_DISP:
                rd_next = frm_rdata;
            default: ;
        endcase
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MODE_RUN;
            pc_reg    <= PROG_BASE;
            idx_reg   <= 16'd0;
            sp_reg    <= '0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            wait_reg  <= 4'd0;
            fault_reg <= FAULT_NONE;
            cost_reg  <= 15'd0;
            rd_reg    <= 8'd0;
            cnt_reg   <= 12'd0;
            for (int i = 0; i < 16; i++)
            begin
                vreg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            wait_reg  <= wait_next;
            fault_reg <= fault_next;
            cost_reg  <= cost_next;
            rd_reg    <= rd_next;
            cnt_reg   <= cnt_next;
            if (rf_we)
            begin
                vreg[rf_waddr] <= rf_wdata;
            end
        end
    end

    // working registers and return stack
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        rnd_reg  <= rnd_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        flag_reg <= flag_next;
        hit_reg  <= hit_next;
        row_reg  <= row_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        bcd_reg  <= bcd_next;
        if (push)
        begin
            stack_mem[sp_reg[SIW-1:0]] <= pc2;
        end
    end

    // result ports
    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_FINISH);
    assign run_state       = mode_reg;
    assign program_counter = pc_reg;
    assign fault           = fault_reg;
    assign read_data       = rd_reg;
    assign sound_on        = (sound_reg != 8'd0);
    assign cost_us         = cost_reg;

    // checks
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("done not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (fault != FAULT_NONE)) |-> (run_state == MODE_STOP && cost_us == 15'd0))
        else $error("fault without stop");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack count beyond depth");

endmodule

`default_nettype wire

// File: dv/chip8_cpu_core_top_tb.sv
`default_nettype none

module chip8_cpu_core_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c8_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic [1:0]  run_state;
        logic [11:0] program_counter;
        logic [1:0]  fault;
        logic [7:0]  read_data;
        logic        sound_on;
        logic [14:0] cost_us;
    } c8_result_t;

    // predictor of the core plus the queue of beats it owes
    class c8_scoreboard;
        logic [7:0]  mem [MEM_BYTES];
        logic [7:0]  v [16];
        logic [15:0] idx;
        logic [11:0] pc;
        logic [11:0] stk [STACK_DEPTH];
        int          sp;
        logic [7:0]  dly;
        logic [7:0]  snd;
        logic [7:0]  frame [FRAME_BYTES];
        logic [1:0]  mode;
        logic [3:0]  wdest;
        c8_result_t  pending [$];
        int          errors;

        function void reset_state();
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < FONT_LEN; i++) mem[FONT_BASE + i] = FONT_ROM[i];
            foreach (v[i]) v[i] = 8'h00;
            foreach (stk[i]) stk[i] = 12'h000;
            foreach (frame[i]) frame[i] = 8'h00;
            idx = 16'h0000;
            pc = PROG_BASE;
            sp = 0;
            dly = 8'h00;
            snd = 8'h00;
            mode = MODE_RUN;
            wdest = 4'h0;
            errors = 0;
        endfunction

        function logic [7:0] rd_mem(logic [31:0] a);
            return mem[a[11:0]];
        endfunction

        function void stop(output logic [1:0] f, input logic [1:0] code);
            mode = MODE_STOP;
            f = code;
        endfunction

        // one instruction; returns its cost
        function logic [14:0] run_instr(logic [15:0] keys, logic [7:0] rnd,
                                        output logic [1:0] f);
            logic [7:0]  hi, lo, vy, a, r, fl, row, m, m2, hit;
            logic [3:0]  op, x, y, n;
            logic [11:0] nnn;
            logic [5:0]  px;
            logic [4:0]  py;
            logic [2:0]  sh;
            logic [7:0]  d, d2;
            f = FAULT_NONE;
            hi = rd_mem(pc);
            lo = rd_mem(pc + 1);
            op = hi[7:4]; x = hi[3:0]; y = lo[7:4]; n = lo[3:0];
            nnn = {x, lo};
            vy = v[y];
            pc = pc + 12'd2;
            case (op)
                OP_SYS:
                begin
                    if (hi == 8'h00 && lo == 8'he0)
                    begin
                        foreach (frame[i]) frame[i] = 8'h00;
                        return COST_CLS;
                    end
                    if (hi == 8'h00 && lo == 8'hee)
                    begin
                        if (sp == 0)
                        begin
                            stop(f, FAULT_UNDERFLOW);
                            return 0;
                        end
                        sp--;
                        pc = stk[sp];
                        return COST_JUMP;
                    end
                end
                OP_JP:
                begin
                    pc = nnn;
                    return COST_JUMP;
                end
                OP_CALL:
                begin
                    if (sp >= STACK_DEPTH)
                    begin
                        stop(f, FAULT_OVERFLOW);
                        return 0;
                    end
                    stk[sp] = pc;
                    sp++;
                    pc = nnn;
                    return COST_JUMP;
                end
                OP_SEB:
                begin
                    if (v[x] == lo) pc = pc + 12'd2;
                    return COST_SKB;
                end
                OP_SNEB:
                begin
                    if (v[x] != lo) pc = pc + 12'd2;
                    return COST_SKB;
                end
                OP_SER:
                begin
                    if (n == 4'h0)
                    begin
                        if (v[x] == vy) pc = pc + 12'd2;
                        return COST_SKR;
                    end
                end
                OP_LDB:
                begin
                    v[x] = lo;
                    return COST_LDB;
                end
                OP_ADDB:
                begin
                    v[x] = v[x] + lo;
                    return COST_MOV;
                end
                OP_ALU:
                begin
                    a = v[x];
                    case (n)
                        4'h0:
                        begin
                            v[x] = vy;
                            return COST_ALU;
                        end
                        4'h1: begin r = a | vy; fl = 0; end
                        4'h2: begin r = a & vy; fl = 0; end
                        4'h3: begin r = a ^ vy; fl = 0; end
                        4'h4: begin r = a + vy; fl = {7'd0, r < a}; end
                        4'h5: begin r = a - vy; fl = {7'd0, a >= vy}; end
                        4'h6: begin r = vy >> 1; fl = {7'd0, vy[0]}; end
                        4'h7: begin r = vy - a; fl = {7'd0, vy >= a}; end
                        4'he: begin r = vy << 1; fl = {7'd0, vy[7]}; end
                        default:
                        begin
                            stop(f, FAULT_OPCODE);
                            return 0;
                        end
                    endcase
                    v[x] = r;
                    v[15] = fl;
                    return COST_ALU;
                end
                OP_SNER:
                begin
                    if (n == 4'h0)
                    begin
                        if (v[x] != vy) pc = pc + 12'd2;
                        return COST_SKR;
                    end
                end
                OP_LDI:
                begin
                    idx = {4'h0, nnn};
                    return COST_SKB;
                end
                OP_JPV0:
                begin
                    pc = nnn + {4'h0, v[0]};
                    return COST_JUMP;
                end
                OP_RND:
                begin
                    v[x] = rnd & lo;
                    return COST_RND;
                end
                OP_DRW:
                begin
                    px = v[x][5:0];
                    py = vy[4:0];
                    sh = px[2:0];
                    hit = 0;
                    for (int k = 0; k < n; k++)
                    begin
                        row = rd_mem(idx + k);
                        d = {py + 5'(k), px[5:3]};
                        m = row >> sh;
                        hit |= frame[d] & m;
                        frame[d] ^= m;
                        if (sh != 0)
                        begin
                            d2 = (px < 56) ? d + 8'd1 : d - 8'd7;
                            m2 = row << (4'd8 - sh);
                            hit |= frame[d2] & m2;
                            frame[d2] ^= m2;
                        end
                    end
                    v[15] = {7'd0, hit != 0};
                    return COST_DRW;
                end
                OP_KEY:
                begin
                    if (lo == 8'h9e || lo == 8'ha1)
                    begin
                        // key numbers above 15 count as released
                        if ((v[x] <= 15 && keys[v[x][3:0]]) == (lo == 8'h9e))
                            pc = pc + 12'd2;
                        return COST_SKR;
                    end
                end
                default:
                begin
                    case (lo)
                        8'h07: begin v[x] = dly; return COST_MOV; end
                        8'h0a: begin wdest = x; mode = MODE_WAIT; return 0; end
                        8'h15: begin dly = v[x]; return COST_MOV; end
                        8'h18: begin snd = v[x]; return COST_MOV; end
                        8'h1e: begin idx = idx + v[x]; return COST_ADDI; end
                        8'h29:
                        begin
                            idx = FONT_BASE + v[x] * 16'd5;
                            return COST_FONT;
                        end
                        8'h33:
                        begin
                            mem[idx[11:0]] = v[x] / 100;
                            mem[12'(idx + 1)] = v[x] / 10 % 10;
                            mem[12'(idx + 2)] = v[x] % 10;
                            return COST_BCD;
                        end
                        8'h55:
                        begin
                            for (int k = 0; k <= x; k++) mem[12'(idx + k)] = v[k];
                            idx = idx + x + 16'd1;
                            return COST_BLK;
                        end
                        8'h65:
                        begin
                            for (int k = 0; k <= x; k++) v[k] = rd_mem(idx + k);
                            idx = idx + x + 16'd1;
                            return COST_BLK;
                        end
                        default: ;
                    endcase
                end
            endcase
            stop(f, FAULT_OPCODE);
            return 0;
        endfunction

        // accepted input beat: advance the predictor and queue its result
        function void note_item(logic [2:0] act, logic [11:0] addr, logic [7:0] data,
                                logic [15:0] keys, logic [3:0] rkey, logic [7:0] rnd);
            c8_result_t e;
            e = '0;
            case (act)
                ACT_LOAD: mem[addr] = data;
                ACT_EXEC:
                    if (mode == MODE_RUN) e.cost_us = run_instr(keys, rnd, e.fault);
                ACT_TICK:
                    if (mode != MODE_STOP)
                    begin
                        if (dly != 0) dly--;
                        if (snd != 0) snd--;
                    end
                ACT_KEY:
                    if (mode == MODE_WAIT)
                    begin
                        v[wdest] = {4'h0, rkey};
                        mode = MODE_RUN;
                    end
                ACT_READ: e.read_data = frame[addr[7:0]];
                default: ;
            endcase
            e.run_state = mode;
            e.program_counter = pc;
            e.sound_on = snd != 0;
            pending.push_back(e);
        endfunction

        // result beat from the core against the oldest expectation
        function void check_result(c8_result_t got);
            c8_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.run_state != e.run_state)
            begin
                $display("%0t: run_state exp %0d got %0d", $time, e.run_state, got.run_state);
                errors++;
            end
            if (got.program_counter != e.program_counter)
            begin
                $display("%0t: program_counter exp %h got %h", $time,
                         e.program_counter, got.program_counter);
                errors++;
            end
            if (got.fault != e.fault)
            begin
                $display("%0t: fault exp %0d got %0d", $time, e.fault, got.fault);
                errors++;
            end
            if (got.read_data != e.read_data)
            begin
                $display("%0t: read_data exp %h got %h", $time, e.read_data, got.read_data);
                errors++;
            end
            if (got.sound_on != e.sound_on)
            begin
                $display("%0t: sound_on exp %0d got %0d", $time, e.sound_on, got.sound_on);
                errors++;
            end
            if (got.cost_us != e.cost_us)
            begin
                $display("%0t: cost_us exp %0d got %0d", $time, e.cost_us, got.cost_us);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [11:0] address;
    logic [7:0]  load_data;
    logic [15:0] key_mask;
    logic [3:0]  released_key;
    logic [7:0]  random_byte;
    logic        done;
    logic [1:0]  run_state;
    logic [11:0] program_counter;
    logic [1:0]  fault;
    logic [7:0]  read_data;
    logic        sound_on;
    logic [14:0] cost_us;

    c8_scoreboard sb;
    int           stall_cycles;
    bit           no_idle;
    int           item_count;

    localparam int WATCHDOG_LIMIT = 30000;

    chip8_cpu_core_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .address(address), .load_data(load_data),
        .key_mask(key_mask), .released_key(released_key), .random_byte(random_byte),
        .done(done), .run_state(run_state), .program_counter(program_counter),
        .fault(fault), .read_data(read_data), .sound_on(sound_on), .cost_us(cost_us)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result({run_state, program_counter, fault, read_data,
                                 sound_on, cost_us});
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one command beat, with a random hold-off before it unless no_idle is set
    task automatic send_item(logic [2:0] act, logic [11:0] addr, logic [7:0] data,
                             logic [15:0] keys, logic [3:0] rkey, logic [7:0] rnd);
        int  gap;
        bit  taken;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        address      <= addr;
        load_data    <= data;
        key_mask     <= keys;
        released_key <= rkey;
        random_byte  <= rnd;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        sb.note_item(act, addr, data, keys, rkey, rnd);
        item_count++;
        if (item_count % 100 == 0 && $urandom_range(0, 9) < 3) no_idle = !no_idle;
    endtask

    task automatic send_simple(logic [2:0] act, logic [11:0] addr, logic [7:0] data);
        send_item(act, addr, data, 16'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // place an instruction at the predicted pc and execute it
    task automatic run_op(logic [15:0] opw);
        send_simple(ACT_LOAD, sb.pc, opw[15:8]);
        send_simple(ACT_LOAD, sb.pc + 12'd1, opw[7:0]);
        send_simple(ACT_EXEC, 12'($urandom), 8'($urandom));
    endtask

    // random well-formed instruction that cannot stop the core
    function automatic logic [15:0] pick_op();
        logic [3:0]  op;
        logic [11:0] r;
        logic [7:0]  flo [9];
        logic [3:0]  alu [9];
        flo = '{8'h07, 8'h0a, 8'h15, 8'h18, 8'h1e, 8'h29, 8'h33, 8'h55, 8'h65};
        alu = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'he};
        r = 12'($urandom);
        op = 4'($urandom);
        case (op)
            OP_SYS:
                return (sb.sp > 0 && $urandom_range(0, 1)) ? 16'h00ee : 16'h00e0;
            OP_CALL:
                return (sb.sp < STACK_DEPTH) ? {OP_CALL, r} : {OP_JP, r};
            OP_SER, OP_SNER: return {op, r[11:4], 4'h0};
            OP_ALU: return {op, r[11:4], alu[$urandom_range(0, 8)]};
            OP_DRW: return {op, r[11:4], 4'($urandom_range(0, 15))};
            OP_KEY: return {op, r[11:8], $urandom_range(0, 1) ? 8'h9e : 8'ha1};
            OP_MISC: return {op, r[11:8], flo[$urandom_range(0, 8)]};
            default: return {op, r};
        endcase
    endfunction

    initial
    begin
        int kind;
        int r;
        sb = new();
        sb.reset_state();
        stall_cycles = 0;
        no_idle = 1'b0;
        item_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOAD;
        address = '0;
        load_data = '0;
        key_mask = '0;
        released_key = '0;
        random_byte = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, flags, wrap, wait for key
        run_op(16'h60ff);
        run_op(16'h61ff);
        run_op(16'h8014);
        run_op(16'h6f3f);
        run_op(16'hd0f5);
        run_op(16'hf033);
        run_op(16'hf00a);
        send_item(ACT_KEY, 12'hfff, 8'hff, 16'hffff, 4'hf, 8'hff);
        send_item(ACT_READ, 12'hfff, 8'h00, 16'h0000, 4'h0, 8'h00);
        send_item(ACT_TICK, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);
        send_item(3'd7, 12'h000, 8'h00, 16'h0000, 4'h0, 8'h00);

        // random: mostly programs written just ahead of the pc
        while (item_count < 1950)
        begin
            r = $urandom_range(0, 99);
            if (sb.mode == MODE_WAIT && r < 80)
                send_simple(ACT_KEY, 12'($urandom), 8'($urandom));
            else if (r < 55)
                run_op(pick_op());
            else if (r < 67)
                send_simple(ACT_LOAD, 12'($urandom), 8'($urandom));
            else if (r < 80)
                send_simple(ACT_TICK, 12'($urandom), 8'($urandom));
            else if (r < 90)
                send_simple(ACT_READ, 12'($urandom), 8'($urandom));
            else if (r < 95)
                send_simple(ACT_KEY, 12'($urandom), 8'($urandom));
            else
                send_simple(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom));
        end

        // one way of stopping the core, then items sent to it; execute, tick and key are ignored
        if (sb.mode == MODE_WAIT) send_simple(ACT_KEY, 12'h000, 8'h00);
        kind = $urandom_range(0, 2);
        if (kind == 0)
            run_op(16'h0123);
        else if (kind == 1)
        begin
            while (sb.sp > 0) run_op(16'h00ee);
            run_op(16'h00ee);
        end
        else
        begin
            while (sb.sp < STACK_DEPTH) run_op({OP_CALL, 12'($urandom)});
            run_op({OP_CALL, 12'($urandom)});
        end
        run_op(16'h6012);
        send_simple(ACT_TICK, 12'h000, 8'h00);
        send_simple(ACT_KEY, 12'h000, 8'h00);
        send_simple(ACT_READ, 12'($urandom), 8'h00);
        start <= 1'b0;

        // drain, then watch for stray beats
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
